@@ src/pcis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pcis_pkg;

  // Field widths of the channels.
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int TICK_W  = 14;
  localparam int PRIO_W  = 8;
  localparam int CNT_W   = 5;
  localparam int DUR_W   = 12;
  localparam int ETIME_W = 15;
  localparam int EST_W   = 3;
  localparam int OPK_W   = 2;
  localparam int IOT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD_PROC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_OP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LIMIT = 2'd1;

  // Trace entry states.
  localparam logic [EST_W-1:0] EST_RUNNING = 3'd0;
  localparam logic [EST_W-1:0] EST_WAITING = 3'd1;
  localparam logic [EST_W-1:0] EST_TERM    = 3'd2;
  localparam logic [EST_W-1:0] EST_IDLE    = 3'd3;
  localparam logic [EST_W-1:0] EST_OVER    = 3'd4;

  // Operation kinds in the trace.
  localparam logic [OPK_W-1:0] OPK_NONE = 2'd0;
  localparam logic [OPK_W-1:0] OPK_CPU  = 2'd1;
  localparam logic [OPK_W-1:0] OPK_IO   = 2'd2;

  localparam logic [IOT_W-1:0]  NO_IO          = 16'hFFFF;
  localparam logic [TICK_W-1:0] DEFAULT_LIMIT  = 14'd10000;

  typedef struct packed {
    logic [SLOT_W-1:0]  idx;
    logic [ETIME_W-1:0] etime;
    logic [EST_W-1:0]   st;
    logic [OPK_W-1:0]   opk;
  } entry_t;

endpackage
`default_nettype wire

@@ src/pcis_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface pcis_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcis_pkg::KIND_W-1:0] kind;
  logic [pcis_pkg::SLOT_W-1:0] proc_slot;
  logic [pcis_pkg::TICK_W-1:0] arrival_time;
  logic [pcis_pkg::PRIO_W-1:0] priority_req;
  logic [pcis_pkg::CNT_W-1:0]  op_count;
  logic [pcis_pkg::SLOT_W-1:0] op_slot;
  logic                        op_type;
  logic [pcis_pkg::DUR_W-1:0]  op_duration;
  modport source (output valid, kind, proc_slot, arrival_time, priority_req, op_count,
                  op_slot, op_type, op_duration, input ready);
  modport sink (input valid, kind, proc_slot, arrival_time, priority_req, op_count,
                op_slot, op_type, op_duration, output ready);
endinterface

interface pcis_out_if;
  logic                         valid;
  logic                         ready;
  logic [pcis_pkg::SLOT_W-1:0]  process_index;
  logic [pcis_pkg::ETIME_W-1:0] entry_time;
  logic [pcis_pkg::EST_W-1:0]   entry_state;
  logic [pcis_pkg::OPK_W-1:0]   operation_kind;
  logic                         last_entry;
  modport source (output valid, process_index, entry_time, entry_state, operation_kind,
                  last_entry, input ready);
  modport sink (input valid, process_index, entry_time, entry_state, operation_kind,
                last_entry, output ready);
endinterface

interface pcis_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pcis_pkg::CFG_IDX_W-1:0]  index;
  logic [pcis_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/priority_cpu_io_scheduler_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Preemptive priority scheduler with one CPU and one I/O device. Loads of a
// process or an operation are taken while the unit is idle. For N slots in use
// (N from process_count, capped at MAX_PROCS), a tick runs the selection scan,
// a decision step, the CPU and I/O issue steps, the waiting and termination
// passes and a flush; a stall at the result side can hold it. The scan reads
// the operation memory once per slot through its single registered read port.
// The waiting and termination passes visit one slot per cycle each while the
// output does not stall, and the flush emits the last entry. Once the run is
// over, a tick yields a single status entry. Results of a tick leave at most
// one per cycle through an output register; the final one carries last_entry.
module priority_cpu_io_scheduler_unit #(
  parameter int MAX_PROCS = 16,
  parameter int MAX_OPS   = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pcis_in_if.sink   in_if,
  pcis_out_if.source out_if,
  pcis_cfg_if.sink  cfg_if
);
  import pcis_pkg::*;

  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int KW = $clog2(MAX_PROCS + 1);
  localparam int CW = $clog2(MAX_OPS + 1);
  localparam int AW = (MAX_PROCS * MAX_OPS > 1) ? $clog2(MAX_PROCS * MAX_OPS) : 1;
  localparam int MW = 1 + DUR_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EV    = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_CPU   = 4'd4;
  localparam logic [3:0] S_IO    = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_TERM  = 4'd7;
  localparam logic [3:0] S_FLUSH = 4'd8;

  // Process tables and the operation memory.
  logic [TICK_W-1:0] arrival_r  [MAX_PROCS];
  logic [PRIO_W-1:0] prio_r     [MAX_PROCS];
  logic [CW-1:0]     tot_r      [MAX_PROCS];
  logic [CW-1:0]     pos_r      [MAX_PROCS];
  logic [DUR_W-1:0]  rem_r      [MAX_PROCS];
  logic [IOT_W-1:0]  io_end_r   [MAX_PROCS];
  logic              fin_r      [MAX_PROCS];
  logic [MW-1:0]     op_mem     [MAX_PROCS * MAX_OPS];
  logic [MW-1:0]     mem_q_r;

  logic [CNT_W-1:0]  pc_r;
  logic [TICK_W-1:0] limit_r;
  logic [TICK_W-1:0] tick_r;
  logic [3:0]        state_r;
  logic [KW-1:0]     k_r;

  // Selection results of the scan.
  logic              over_r;
  logic              cpu_v_r, iob_v_r, ion_v_r, io_v_r;
  logic [PW-1:0]     cpu_idx_r, iob_idx_r, ion_idx_r, io_idx_r;
  logic [PRIO_W-1:0] cpu_pri_r, ion_pri_r;
  logic [DUR_W-1:0]  cpu_dur_r, ion_dur_r;
  logic [IOT_W-1:0]  io_end_eff_r;

  // Output register and the held-back entry that decides last_entry.
  entry_t            out_r, pend_r;
  logic              out_valid_r, out_last_r, pend_v_r;

  logic [KW-1:0]     np;
  logic [PW-1:0]     kk;
  logic              k_done, k_arr, k_noio, k_hasop, out_free, can_emit, out_load;
  logic [DUR_W-1:0]  mem_dur, cpu_rem;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CW-1:0]     load_cnt;

  // Slot view for the scan counter.
  always_comb begin
    np       = (int'(pc_r) > MAX_PROCS) ? KW'(MAX_PROCS) : KW'(pc_r);
    kk       = k_r[PW-1:0];
    k_done   = fin_r[kk] || (tot_r[kk] == '0);
    k_arr    = arrival_r[kk] <= tick_r;
    k_noio   = io_end_r[kk] == NO_IO;
    k_hasop  = pos_r[kk] < tot_r[kk];
    mem_dur  = (mem_q_r[DUR_W-1:0] == '0) ? DUR_W'(1) : mem_q_r[DUR_W-1:0];
    cpu_rem  = (rem_r[cpu_idx_r] == '0) ? cpu_dur_r : rem_r[cpu_idx_r];
    out_free = !out_valid_r || out_if.ready;
    can_emit = !pend_v_r || out_free;
    rd_addr  = AW'(int'(kk) * MAX_OPS + int'(pos_r[kk]));
    wr_addr  = AW'(int'(in_if.proc_slot) * MAX_OPS + int'(in_if.op_slot));
    load_cnt = (int'(in_if.op_count) > MAX_OPS) ? CW'(MAX_OPS) : CW'(in_if.op_count);
  end

  // The output register takes a new entry when a held entry moves on or at the flush.
  always_comb begin
    unique case (state_r)
      S_CPU:   out_load = cpu_v_r && can_emit && pend_v_r;
      S_IO:    out_load = io_v_r && can_emit && pend_v_r;
      S_WAIT:  out_load = (k_r != np) && !k_done && k_arr &&
                          !(cpu_v_r && kk == cpu_idx_r) && !(io_v_r && kk == io_idx_r) &&
                          can_emit && pend_v_r;
      S_TERM:  out_load = (k_r != np) && !k_done && k_arr && !k_hasop && k_noio &&
                          can_emit && pend_v_r;
      S_FLUSH: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  // Operation memory: load writes and the scan read.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_if.valid && in_if.kind == KIND_LOAD_OP &&
        int'(in_if.proc_slot) < MAX_PROCS && int'(in_if.op_slot) < MAX_OPS) begin
      op_mem[wr_addr] <= {in_if.op_type, in_if.op_duration};
    end
    mem_q_r <= op_mem[rd_addr];
  end

  // Process payload tables.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_if.valid && in_if.kind == KIND_LOAD_PROC &&
        int'(in_if.proc_slot) < MAX_PROCS) begin
      arrival_r[PW'(in_if.proc_slot)] <= in_if.arrival_time;
      prio_r[PW'(in_if.proc_slot)]    <= in_if.priority_req;
      tot_r[PW'(in_if.proc_slot)]     <= load_cnt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= '0;
      limit_r <= DEFAULT_LIMIT;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_PROC_COUNT: pc_r    <= cfg_if.data[CNT_W-1:0];
        CFG_TICK_LIMIT: limit_r <= cfg_if.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick sequencer with result emission.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        pos_r[i]    <= '0;
        rem_r[i]    <= '0;
        io_end_r[i] <= NO_IO;
        fin_r[i]    <= 1'b0;
      end
    end else begin
      // The output stays valid until its transfer unless a new entry replaces it.
      out_valid_r <= out_load || (out_valid_r && !out_if.ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid && in_if.kind == KIND_LOAD_PROC &&
              int'(in_if.proc_slot) < MAX_PROCS) begin
            pos_r[PW'(in_if.proc_slot)]    <= '0;
            rem_r[PW'(in_if.proc_slot)]    <= '0;
            io_end_r[PW'(in_if.proc_slot)] <= NO_IO;
            fin_r[PW'(in_if.proc_slot)]    <= 1'b0;
          end else if (in_if.valid && in_if.kind == KIND_TICK) begin
            k_r     <= '0;
            over_r  <= 1'b1;
            cpu_v_r <= 1'b0;
            iob_v_r <= 1'b0;
            ion_v_r <= 1'b0;
            state_r <= (np == '0) ? S_DEC : S_RD;
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: begin
          // Candidate checks for one slot.
          if (!k_done) over_r <= 1'b0;
          if (!k_done && k_arr && k_noio && k_hasop && !mem_q_r[DUR_W] &&
              (!cpu_v_r || prio_r[kk] > cpu_pri_r)) begin
            cpu_v_r   <= 1'b1;
            cpu_idx_r <= kk;
            cpu_pri_r <= prio_r[kk];
            cpu_dur_r <= mem_dur;
          end
          if (!k_done && k_arr && !k_noio && io_end_r[kk] > IOT_W'(tick_r) && !iob_v_r) begin
            iob_v_r   <= 1'b1;
            iob_idx_r <= kk;
          end
          if (!k_done && k_arr && k_noio && k_hasop && mem_q_r[DUR_W] &&
              (!ion_v_r || prio_r[kk] > ion_pri_r)) begin
            ion_v_r   <= 1'b1;
            ion_idx_r <= kk;
            ion_pri_r <= prio_r[kk];
            ion_dur_r <= mem_dur;
          end
          if (k_r + KW'(1) == np) state_r <= S_DEC;
          else begin
            k_r     <= k_r + KW'(1);
            state_r <= S_RD;
          end
        end
        S_DEC: begin
          if (over_r || tick_r >= limit_r) begin
            pend_v_r <= 1'b1;
            pend_r   <= '{idx: '0, etime: ETIME_W'(tick_r), st: EST_OVER, opk: OPK_NONE};
            state_r  <= S_FLUSH;
          end else begin
            io_v_r <= iob_v_r || ion_v_r;
            if (iob_v_r) begin
              io_idx_r     <= iob_idx_r;
              io_end_eff_r <= io_end_r[iob_idx_r];
            end else begin
              io_idx_r     <= ion_idx_r;
              io_end_eff_r <= IOT_W'(tick_r) + IOT_W'(ion_dur_r);
              if (ion_v_r) io_end_r[ion_idx_r] <= IOT_W'(tick_r) + IOT_W'(ion_dur_r);
            end
            state_r <= S_CPU;
          end
        end
        S_CPU: begin
          if (!cpu_v_r) state_r <= S_IO;
          else if (can_emit) begin
            if (pend_v_r) begin
              out_r       <= pend_r;
              out_last_r  <= 1'b0;
            end
            pend_v_r <= 1'b1;
            pend_r   <= '{idx: SLOT_W'(cpu_idx_r), etime: ETIME_W'(tick_r),
                          st: EST_RUNNING, opk: OPK_CPU};
            rem_r[cpu_idx_r] <= cpu_rem - DUR_W'(1);
            if (cpu_rem == DUR_W'(1)) pos_r[cpu_idx_r] <= pos_r[cpu_idx_r] + CW'(1);
            state_r <= S_IO;
          end
        end
        S_IO: begin
          if (!io_v_r) begin
            k_r     <= '0;
            state_r <= S_WAIT;
          end else if (can_emit) begin
            if (pend_v_r) begin
              out_r       <= pend_r;
              out_last_r  <= 1'b0;
            end
            pend_v_r <= 1'b1;
            pend_r   <= '{idx: SLOT_W'(io_idx_r), etime: ETIME_W'(tick_r),
                          st: EST_RUNNING, opk: OPK_IO};
            if (io_end_eff_r <= IOT_W'(tick_r) + IOT_W'(1)) begin
              pos_r[io_idx_r]    <= pos_r[io_idx_r] + CW'(1);
              io_end_r[io_idx_r] <= NO_IO;
              rem_r[io_idx_r]    <= '0;
            end
            k_r     <= '0;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          // Waiting entries for arrived, unfinished slots that did not run.
          if (k_r == np) begin
            k_r     <= '0;
            state_r <= S_TERM;
          end else if (!k_done && k_arr && !(cpu_v_r && kk == cpu_idx_r) &&
                       !(io_v_r && kk == io_idx_r)) begin
            if (can_emit) begin
              if (pend_v_r) begin
                out_r       <= pend_r;
                out_last_r  <= 1'b0;
              end
              pend_v_r <= 1'b1;
              pend_r   <= '{idx: SLOT_W'(kk), etime: ETIME_W'(tick_r),
                            st: EST_WAITING, opk: OPK_NONE};
              k_r <= k_r + KW'(1);
            end
          end else k_r <= k_r + KW'(1);
        end
        S_TERM: begin
          // Terminations of slots with no operation left and no I/O open.
          if (k_r == np) begin
            state_r <= S_FLUSH;
          end else if (!k_done && k_arr && !k_hasop && k_noio) begin
            if (can_emit) begin
              if (pend_v_r) begin
                out_r       <= pend_r;
                out_last_r  <= 1'b0;
              end
              pend_v_r  <= 1'b1;
              pend_r    <= '{idx: SLOT_W'(kk), etime: ETIME_W'(tick_r) + ETIME_W'(1),
                             st: EST_TERM, opk: OPK_NONE};
              fin_r[kk] <= 1'b1;
              k_r       <= k_r + KW'(1);
            end
          end else k_r <= k_r + KW'(1);
        end
        S_FLUSH: begin
          if (out_free) begin
            out_r       <= pend_v_r ? pend_r :
                           '{idx: '0, etime: ETIME_W'(tick_r), st: EST_IDLE, opk: OPK_NONE};
            out_last_r  <= 1'b1;
            pend_v_r    <= 1'b0;
            if (!(pend_v_r && pend_r.st == EST_OVER)) tick_r <= tick_r + TICK_W'(1);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready           = state_r == S_IDLE;
  assign cfg_if.ready          = 1'b1;
  assign out_if.valid          = out_valid_r;
  assign out_if.process_index  = out_r.idx;
  assign out_if.entry_time     = out_r.etime;
  assign out_if.entry_state    = out_r.st;
  assign out_if.operation_kind = out_r.opk;
  assign out_if.last_entry     = out_last_r;

  // Nothing is held back between ticks.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r) else $error("held entry left over after a tick");

  // The CPU and the I/O device never serve the same slot.
  a_cpu_io_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CPU && cpu_v_r && io_v_r) |-> cpu_idx_r != io_idx_r)
    else $error("CPU and I/O picked the same slot");

  // A flush with room at the output closes the tick with a last entry.
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && out_free) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("tick not closed by a last entry");

endmodule
`default_nettype wire
